[design/ppm_pkg.sv]
// Package for the pedal plausibility mapper.
// Sequencer states, item opcodes, register indexes and reset constants.
// No dependencies.
package ppm_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam logic [7:0]  DZ_RESET          = 8'd10;
    localparam logic [15:0] FAULT_TICKS_RESET = 16'd100;
    localparam logic [7:0]  EXT_MIN_RESET     = 8'hFF;
    localparam logic [7:0]  FULL_SCALE        = 8'd255;
    localparam logic [15:0] TICK_SAT          = 16'hFFFF;

    // span / 10 as (span * 205) >> 11, exact for spans below 1029
    localparam logic [7:0]  DIV10_MUL   = 8'd205;
    localparam int          DIV10_SHIFT = 11;

    typedef enum logic [1:0] {
        OP_CAL  = 2'd0,
        OP_END  = 2'd1,
        OP_RUN  = 2'd2,
        OP_TICK = 2'd3
    } op_t;

    localparam logic [1:0] CFG_DZ_LOW      = 2'd0;
    localparam logic [1:0] CFG_DZ_HIGH     = 2'd1;
    localparam logic [1:0] CFG_FAULT_TICKS = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

[design/pedal_plausibility_mapper_top.sv]
// Pedal plausibility mapper: calibration table, plausibility check, position map.
// Uses ppm_pkg. One shared compare/subtract unit does the mapping divide.
//
// Channel   Dir  Handshake                 Contents
// s_*       in   s_tvalid / s_tready       tuser: opcode; tdata: rotary, linear
// m_*       out  m_tvalid / m_tready       tdata: position; tuser: mismatch, fault
// cfg_*     in   cfg_we (no wait)          cfg_index, cfg_wdata
//
// Calibrate, end-calibration and tick items go from the idle state straight to the output load.
// Run items go through table read, check, 8 divide steps when a divide is needed, and output load;
// the restoring divide loop produces one quotient bit per cycle.
// After reset a clearing pass writes TABLE_DEPTH zero entries, one per cycle,
// with s_tready low. A full output register stalls the sequencer in its last step.
module pedal_plausibility_mapper_top #(
    parameter int TABLE_DEPTH = ppm_pkg::TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rotary, [15:8] linear
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] position
    output logic [1:0]  m_tuser,   // [0] mismatch, [1] fault
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    ppm_pkg::state_t state_reg, state_next;

    logic [7:0]  mem [TABLE_DEPTH];
    logic [7:0]  rdata_reg;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic [7:0]  dz_low_reg, dz_high_reg;
    logic [15:0] fault_ticks_reg;

    logic [7:0]  rot_min_reg, rot_min_next, rot_max_reg, rot_max_next;
    logic [7:0]  lin_min_reg, lin_min_next, lin_max_reg, lin_max_next;
    logic [4:0]  tol_reg, tol_next;
    logic        timer_reg, timer_next;
    logic [15:0] tick_reg, tick_next;
    logic        fault_reg, fault_next;

    logic [7:0]  rot_reg, rot_next, lin_reg, lin_next;
    logic [16:0] rem_reg, rem_next, dsh_reg, dsh_next;
    logic [2:0]  step_reg, step_next;
    logic [7:0]  pos_reg, pos_next;
    logic        mis_reg, mis_next;
    logic        go_div;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_pos_reg, out_pos_next;
    logic        out_mis_reg, out_mis_next;
    logic        out_fault_reg, out_fault_next;

    logic        accept, out_free;
    ppm_pkg::op_t op_in;
    logic [7:0]  rot_in, lin_in;
    logic        mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [7:0]  mem_wdata;

    assign op_in    = ppm_pkg::op_t'(s_tuser);
    assign rot_in   = s_tdata[7:0];
    assign lin_in   = s_tdata[15:8];
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pos_reg;
    assign m_tuser  = {out_fault_reg, out_mis_reg};

    // ---------------- mapping arithmetic (shared by check step) ----------------
    logic [9:0]         lo;
    logic signed [10:0] hi, span_s, num_s;
    logic [9:0]         d_mag;
    logic [8:0]         n_mag;
    logic [16:0]        n_x255;
    logic [7:0]         entry;
    logic               ok;
    logic               rot_ok_run;

    always_comb
    begin
        lo     = {2'b0, rot_min_reg} + {2'b0, dz_low_reg};
        hi     = $signed({3'b0, rot_max_reg}) - $signed({3'b0, dz_high_reg});
        span_s = hi - $signed({1'b0, lo});
        num_s  = $signed({3'b0, rot_reg}) - $signed({1'b0, lo});
        d_mag  = span_s[10] ? 10'(-span_s) : span_s[9:0];
        n_mag  = num_s[10] ? 9'(-num_s) : num_s[8:0];
        n_x255 = {n_mag, 8'b0} - {8'b0, n_mag};
        rot_ok_run = (32'(rot_reg) < TABLE_DEPTH);
        entry  = rot_ok_run ? rdata_reg : 8'd0;
        // strict window: lin - tol < entry < lin + tol
        ok = ({1'b0, entry} < ({1'b0, lin_reg} + {4'b0, tol_reg}))
          && (({1'b0, entry} + {4'b0, tol_reg}) > {1'b0, lin_reg});
        go_div = !(fault_reg || (span_s == 11'sd0) || (num_s == 11'sd0)
                   || (num_s[10] != span_s[10]) || ({1'b0, n_mag} >= d_mag));
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppm_pkg::ST_CLEAR:
                if (clr_cnt_reg == IDX_W'(TABLE_DEPTH - 1))
                    state_next = ppm_pkg::ST_IDLE;
            ppm_pkg::ST_IDLE:
                if (accept)
                    state_next = (op_in == ppm_pkg::OP_RUN) ? ppm_pkg::ST_CHECK
                                                            : ppm_pkg::ST_DONE;
            ppm_pkg::ST_CHECK:
                state_next = go_div ? ppm_pkg::ST_DIV : ppm_pkg::ST_DONE;
            ppm_pkg::ST_DIV:
                if (step_reg == 3'd0)
                    state_next = ppm_pkg::ST_DONE;
            ppm_pkg::ST_DONE:
                if (out_free)
                    state_next = ppm_pkg::ST_IDLE;
            default:
                state_next = ppm_pkg::ST_IDLE;
        endcase
    end

    // ---------------- datapath / outputs ----------------
    logic [7:0]  lin_span;
    logic [15:0] span_prod;
    logic [15:0] tick_inc;
    logic        rem_ge;

    always_comb
    begin
        lin_span  = lin_max_reg - lin_min_reg;
        span_prod = 16'(lin_span * ppm_pkg::DIV10_MUL);
        tick_inc  = (tick_reg == ppm_pkg::TICK_SAT) ? tick_reg : tick_reg + 16'd1;
        rem_ge    = (rem_reg >= dsh_reg);

        s_tready     = (state_reg == ppm_pkg::ST_IDLE);
        clr_cnt_next = clr_cnt_reg;
        rot_min_next = rot_min_reg;
        rot_max_next = rot_max_reg;
        lin_min_next = lin_min_reg;
        lin_max_next = lin_max_reg;
        tol_next     = tol_reg;
        timer_next   = timer_reg;
        tick_next    = tick_reg;
        fault_next   = fault_reg;
        rot_next     = rot_reg;
        lin_next     = lin_reg;
        rem_next     = rem_reg;
        dsh_next     = dsh_reg;
        step_next    = step_reg;
        pos_next     = pos_reg;
        mis_next     = mis_reg;
        mem_we       = 1'b0;
        mem_waddr    = IDX_W'(rot_in);
        mem_wdata    = lin_in;
        out_valid_next = out_valid_reg && !m_tready;
        out_pos_next   = out_pos_reg;
        out_mis_next   = out_mis_reg;
        out_fault_next = out_fault_reg;

        unique case (state_reg)
            ppm_pkg::ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = 8'd0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ppm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    rot_next = rot_in;
                    lin_next = lin_in;
                    pos_next = 8'd0;
                    mis_next = 1'b0;
                    unique case (op_in)
                        ppm_pkg::OP_CAL:
                        begin
                            mem_we = (32'(rot_in) < TABLE_DEPTH);
                            if (rot_in < rot_min_reg) rot_min_next = rot_in;
                            if (rot_in > rot_max_reg) rot_max_next = rot_in;
                            if (lin_in < lin_min_reg) lin_min_next = lin_in;
                            if (lin_in > lin_max_reg) lin_max_next = lin_in;
                        end
                        ppm_pkg::OP_END:
                            tol_next = (lin_max_reg >= lin_min_reg)
                                     ? span_prod[ppm_pkg::DIV10_SHIFT +: 5] : 5'd0;
                        ppm_pkg::OP_RUN:
                        begin
                        end
                        ppm_pkg::OP_TICK:
                            if (timer_reg && !fault_reg)
                            begin
                                tick_next = tick_inc;
                                if (tick_inc >= fault_ticks_reg)
                                    fault_next = 1'b1;
                            end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ppm_pkg::ST_CHECK:
            begin
                mis_next   = !ok;
                timer_next = !ok;
                if (ok)
                    tick_next = 16'd0;
                priority if (go_div)
                begin
                    rem_next  = n_x255;
                    dsh_next  = {d_mag, 7'b0};
                    step_next = 3'd7;
                    pos_next  = 8'd0;
                end
                else if (fault_reg || (span_s == 11'sd0) || (num_s == 11'sd0)
                         || (num_s[10] != span_s[10]))
                    pos_next = 8'd0;
                else
                    pos_next = ppm_pkg::FULL_SCALE;
            end
            ppm_pkg::ST_DIV:
            begin
                // one restoring step: quotient bit shifts into pos_reg
                if (rem_ge)
                    rem_next = rem_reg - dsh_reg;
                dsh_next  = dsh_reg >> 1;
                pos_next  = {pos_reg[6:0], rem_ge};
                step_next = step_reg - 3'd1;
            end
            ppm_pkg::ST_DONE:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = pos_reg;
                    out_mis_next   = mis_reg;
                    out_fault_next = fault_reg;
                end
            default:
            begin
            end
        endcase
    end

    // ---------------- table memory ----------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[IDX_W'(rot_in)];
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ppm_pkg::ST_CLEAR;
            clr_cnt_reg     <= '0;
            dz_low_reg      <= ppm_pkg::DZ_RESET;
            dz_high_reg     <= ppm_pkg::DZ_RESET;
            fault_ticks_reg <= ppm_pkg::FAULT_TICKS_RESET;
            rot_min_reg     <= ppm_pkg::EXT_MIN_RESET;
            rot_max_reg     <= 8'd0;
            lin_min_reg     <= ppm_pkg::EXT_MIN_RESET;
            lin_max_reg     <= 8'd0;
            tol_reg         <= 5'd0;
            timer_reg       <= 1'b0;
            tick_reg        <= 16'd0;
            fault_reg       <= 1'b0;
            step_reg        <= 3'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ppm_pkg::CFG_DZ_LOW:      dz_low_reg      <= cfg_wdata[7:0];
                    ppm_pkg::CFG_DZ_HIGH:     dz_high_reg     <= cfg_wdata[7:0];
                    ppm_pkg::CFG_FAULT_TICKS: fault_ticks_reg <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            rot_min_reg   <= rot_min_next;
            rot_max_reg   <= rot_max_next;
            lin_min_reg   <= lin_min_next;
            lin_max_reg   <= lin_max_next;
            tol_reg       <= tol_next;
            timer_reg     <= timer_next;
            tick_reg      <= tick_next;
            fault_reg     <= fault_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rot_reg       <= rot_next;
        lin_reg       <= lin_next;
        rem_reg       <= rem_next;
        dsh_reg       <= dsh_next;
        pos_reg       <= pos_next;
        mis_reg       <= mis_next;
        out_pos_reg   <= out_pos_next;
        out_mis_reg   <= out_mis_next;
        out_fault_reg <= out_fault_next;
    end

endmodule

[design/ppm_checker.sv]
// Port-level checker for the pedal plausibility mapper, bound to the top level.
// Depends on pedal_plausibility_mapper_top port names only.
module ppm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser
);

    // result waits until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // one item at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while busy");

    // a latched fault forces position 0
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata == 8'd0)
        else $error("nonzero position with fault");

endmodule

bind pedal_plausibility_mapper_top ppm_checker u_ppm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
